FILE: src/sample_gap_linear_interpolator_defines.svh
// Assertion macros shared by the gap interpolator RTL.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef SAMPLE_GAP_LINEAR_INTERPOLATOR_DEFINES_SVH
`define SAMPLE_GAP_LINEAR_INTERPOLATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Plain property, checked on every clock edge outside reset.
`define SGLI_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Same-cycle implication, checked on every clock edge outside reset.
`define SGLI_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define SGLI_ASSERT(lbl, clk, rst_n, prop, msg)
`define SGLI_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: src/sgli_pkg.sv
// Package for the gap interpolator: register map, status codes and shared types.
// No dependencies.
`timescale 1ns / 1ps

package sgli_pkg;

	localparam int MARKER_W  = 16;
	localparam int MAX_GAP_W = 5;
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;
	localparam int REG_LSB   = 2;
	localparam int REG_IDX_W = PADDR_W - REG_LSB;

	localparam logic [REG_IDX_W-1:0] REG_MISSING_MARKER = 1'd0;
	localparam logic [REG_IDX_W-1:0] REG_MAX_GAP        = 1'd1;

	localparam logic [MARKER_W-1:0]  MARKER_RESET  = 16'hD8F1;
	localparam logic [MAX_GAP_W-1:0] MAX_GAP_RESET = 5'd5;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_LEAD  = 2'd1;
	localparam logic [1:0] STAT_INNER = 2'd2;
	localparam logic [1:0] STAT_TRAIL = 2'd3;

	typedef struct packed {
		logic [MARKER_W-1:0]  missing_marker;
		logic [MAX_GAP_W-1:0] max_gap;
	} cfg_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

FILE: src/sgli_if.sv
// Request channels of the gap interpolator: sample input and result output.
// No dependencies.
`timescale 1ns / 1ps

interface sgli_in_if #(parameter int SAMPLE_WIDTH = 16) ();
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample;
	logic                           series_last;

	modport source (output valid, output sample, output series_last, input ready);
	modport sink (input valid, input sample, input series_last, output ready);
endinterface

interface sgli_out_if #(parameter int SAMPLE_WIDTH = 16) ();
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] value;
	logic [1:0]                     status;
	logic                           run_last;
	logic                           series_end;

	modport source (output valid, output value, output status, output run_last,
		output series_end, input ready);
	modport sink (input valid, input value, input status, input run_last,
		input series_end, output ready);
endinterface

FILE: src/sgli_apb.sv
// APB configuration registers of the gap interpolator (missing marker, max gap).
// Depends on sgli_pkg.
`timescale 1ns / 1ps

module sgli_apb import sgli_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	logic [REG_IDX_W-1:0] idx;
	logic                 wr_en;
	cfg_t                 cfg_q;

	assign idx    = paddr[PADDR_W-1:REG_LSB];
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.missing_marker <= MARKER_RESET;
			cfg_q.max_gap        <= MAX_GAP_RESET;
		end else if (wr_en) begin
			case (idx)
				REG_MISSING_MARKER: cfg_q.missing_marker <= pwdata[MARKER_W-1:0];
				REG_MAX_GAP:        cfg_q.max_gap <= pwdata[MAX_GAP_W-1:0];
				default:            cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_MISSING_MARKER: prdata = PDATA_W'(cfg_q.missing_marker);
			REG_MAX_GAP:        prdata = PDATA_W'(cfg_q.max_gap);
			default:            prdata = '0;
		endcase
	end

endmodule

FILE: src/sgli_divider.sv
// Restoring divider, one quotient bit per cycle, shared by every inner-gap fill run.
// Depends on sgli_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "sample_gap_linear_interpolator_defines.svh"

module sgli_divider import sgli_pkg::*; #(
	parameter int DW = 16,
	parameter int VW = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output div_status_t   status,
	output logic [DW-1:0] quotient,
	output logic [VW-1:0] remainder
);

	localparam int CNT_W = $clog2(DW + 1);

	logic [DW-1:0]    dvd_q;
	logic [VW-1:0]    rem_q;
	logic [VW-1:0]    dsr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [VW:0]   trial;
	logic [VW:0]   trial_sub;
	logic          fits;
	logic [VW-1:0] rem_d;

	assign trial     = {rem_q, dvd_q[DW-1]};
	assign trial_sub = trial - {1'b0, dsr_q};
	assign fits      = trial >= {1'b0, dsr_q};
	assign rem_d     = fits ? trial_sub[VW-1:0] : trial[VW-1:0];

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign quotient    = dvd_q;
	assign remainder   = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvd_q  <= '0;
			rem_q  <= '0;
			dsr_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				dvd_q  <= dividend;
				dsr_q  <= divisor;
				rem_q  <= '0;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				dvd_q <= {dvd_q[DW-2:0], fits};
				rem_q <= rem_d;
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	`SGLI_ASSERT_IMPL(a_div_cnt_range, clk, arst_n, busy_q, cnt_q < CNT_W'(DW), "divider step count out of range")
	`SGLI_ASSERT_IMPL(a_div_done_pulse, clk, arst_n, done_q, !busy_q, "divider done while busy")
	`SGLI_ASSERT_IMPL(a_div_divisor_nonzero, clk, arst_n, busy_q, dsr_q != '0, "divide by zero")

endmodule

FILE: src/sample_gap_linear_interpolator.sv
// Gap interpolator top level: sequencer, fill stepper and output register.
// Depends on sgli_pkg, sgli_if, sgli_apb, sgli_divider and the assertion macros.
//
// Usage:
//   samples : sink channel (sample, series_last), accepted when valid & ready.
//   results : source channel (value, status, run_last, series_end), one
//             registered stage; a result is taken when valid & ready.
//   APB     : missing_marker at 0x0, max_gap at 0x4; pready is always high.
// One sample is worked on at a time; samples.ready is high only while idle.
// States from acceptance until ready again:
//   missing sample or dropped sample : IDLE, DECIDE
//   valid sample, no gap             : IDLE, DECIDE, FINAL
//   valid sample after leading gap g : IDLE, DECIDE, EMIT for each of g copies, FINAL
//   valid sample after inner gap g   : IDLE, DECIDE, DIV, EMIT for each of g fills, FINAL
//   (in DIV the bit-serial divider works out one quotient bit per cycle; EMIT then gives
//   one fill value per cycle, while the result port is not stalled, from the shared add/compare step)
// Fill values come out one per cycle unless the result port stalls; the final result carries run_last.
// A stalled result port holds the current result and pauses the sequencer.
// Reset clears the series state and loads the register defaults
// (missing_marker -9999, max_gap 5); no clearing pass is needed.
`timescale 1ns / 1ps
`include "sample_gap_linear_interpolator_defines.svh"

module sample_gap_linear_interpolator import sgli_pkg::*; #(
	parameter int MAX_GAP      = 31,
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	sgli_in_if.sink            samples,
	sgli_out_if.source         results,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	localparam int LIMIT_MAX = (MAX_GAP < 31) ? MAX_GAP : 31;
	localparam int GAP_W     = $clog2(LIMIT_MAX + 2);
	localparam int GCMP_W    = (GAP_W > MAX_GAP_W) ? GAP_W : MAX_GAP_W;
	localparam int CMP_W     = (SAMPLE_WIDTH > MARKER_W) ? SAMPLE_WIDTH : MARKER_W;
	localparam logic [MAX_GAP_W-1:0] LIMIT_CAP = MAX_GAP_W'(LIMIT_MAX);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_DIV,
		ST_EMIT,
		ST_FINAL
	} state_t;

	state_t                         state_q;
	logic signed [SAMPLE_WIDTH-1:0] sample_q;
	logic                           last_q;
	logic signed [SAMPLE_WIDTH-1:0] anchor_q;
	logic [GAP_W-1:0]               gap_q;
	logic                           seen_q;
	logic                           failed_q;
	logic                           copy_q;
	logic                           neg_q;
	logic [GAP_W-1:0]               k_q;
	logic [SAMPLE_WIDTH-1:0]        qs_q;
	logic [GAP_W:0]                 rs_q;
	logic [SAMPLE_WIDTH-1:0]        acc_q;
	logic [GAP_W:0]                 racc_q;
	logic                           out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0] out_value_q;
	logic [1:0]                     out_status_q;
	logic                           out_run_last_q;
	logic                           out_end_q;

	cfg_t                           cfg;
	logic [MAX_GAP_W-1:0]           limit;
	logic signed [CMP_W-1:0]        sample_x;
	logic signed [CMP_W-1:0]        marker_x;
	logic                           is_missing;
	logic [GAP_W-1:0]               gap_inc;
	logic                           too_long;
	logic signed [SAMPLE_WIDTH:0]   diff;
	logic signed [SAMPLE_WIDTH:0]   diff_neg;
	logic [SAMPLE_WIDTH-1:0]        mag;
	logic [GAP_W:0]                 two_den;
	logic [GAP_W+1:0]               rem_sum;
	logic [GAP_W+1:0]               rem_sub;
	logic                           rem_wrap;
	logic [GAP_W:0]                 rem_next;
	logic [SAMPLE_WIDTH-1:0]        quo_next;
	logic signed [SAMPLE_WIDTH:0]   step_s;
	logic signed [SAMPLE_WIDTH:0]   interp_wide;
	logic signed [SAMPLE_WIDTH-1:0] interp_val;
	logic                           push_ok;
	logic                           div_start;
	div_status_t                    div_st;
	logic [SAMPLE_WIDTH-1:0]        div_quo;
	logic [GAP_W-1:0]               div_rem;

	sgli_apb u_apb (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sgli_divider #(
		.DW (SAMPLE_WIDTH),
		.VW (GAP_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (mag),
		.divisor   (gap_inc),
		.status    (div_st),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	always_comb begin
		sample_x    = CMP_W'(sample_q);
		marker_x    = CMP_W'($signed(cfg.missing_marker));
		is_missing  = sample_x == marker_x;
		limit       = (cfg.max_gap < LIMIT_CAP) ? cfg.max_gap : LIMIT_CAP;
		gap_inc     = gap_q + GAP_W'(1);
		too_long    = GCMP_W'(gap_inc) > GCMP_W'(limit);
		diff        = (SAMPLE_WIDTH+1)'(sample_q) - (SAMPLE_WIDTH+1)'(anchor_q);
		diff_neg    = -diff;
		mag         = diff[SAMPLE_WIDTH] ? diff_neg[SAMPLE_WIDTH-1:0]
			: diff[SAMPLE_WIDTH-1:0];
		two_den     = {gap_inc, 1'b0};
		rem_sum     = (GAP_W+2)'(racc_q) + (GAP_W+2)'(rs_q);
		rem_sub     = rem_sum - (GAP_W+2)'(two_den);
		rem_wrap    = rem_sum >= (GAP_W+2)'(two_den);
		rem_next    = rem_wrap ? rem_sub[GAP_W:0] : rem_sum[GAP_W:0];
		quo_next    = acc_q + qs_q + SAMPLE_WIDTH'(rem_wrap);
		step_s      = $signed({1'b0, quo_next});
		interp_wide = (SAMPLE_WIDTH+1)'(anchor_q) + (neg_q ? -step_s : step_s);
		interp_val  = interp_wide[SAMPLE_WIDTH-1:0];
		push_ok     = !out_valid_q || results.ready;
		div_start   = (state_q == ST_DECIDE) && !failed_q && !is_missing && seen_q
			&& (gap_q != '0);
	end

	assign samples.ready      = (state_q == ST_IDLE);
	assign results.valid      = out_valid_q;
	assign results.value      = out_value_q;
	assign results.status     = out_status_q;
	assign results.run_last   = out_run_last_q;
	assign results.series_end = out_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			sample_q       <= '0;
			last_q         <= 1'b0;
			anchor_q       <= '0;
			gap_q          <= '0;
			seen_q         <= 1'b0;
			failed_q       <= 1'b0;
			copy_q         <= 1'b0;
			neg_q          <= 1'b0;
			k_q            <= '0;
			qs_q           <= '0;
			rs_q           <= '0;
			acc_q          <= '0;
			racc_q         <= '0;
			out_valid_q    <= 1'b0;
			out_value_q    <= '0;
			out_status_q   <= STAT_OK;
			out_run_last_q <= 1'b0;
			out_end_q      <= 1'b0;
		end else begin
			if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (samples.valid) begin
						sample_q <= samples.sample;
						last_q   <= samples.series_last;
						state_q  <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (failed_q) begin
						if (last_q) begin
							anchor_q <= '0;
							gap_q    <= '0;
							seen_q   <= 1'b0;
							failed_q <= 1'b0;
						end
						state_q <= ST_IDLE;
					end else if (is_missing) begin
						if (too_long || last_q) begin
							if (push_ok) begin
								out_valid_q    <= 1'b1;
								out_value_q    <= '0;
								out_status_q   <= too_long ? (seen_q ? STAT_INNER : STAT_LEAD)
									: STAT_TRAIL;
								out_run_last_q <= 1'b1;
								out_end_q      <= last_q;
								gap_q          <= gap_inc;
								failed_q       <= too_long;
								if (last_q) begin
									anchor_q <= '0;
									gap_q    <= '0;
									seen_q   <= 1'b0;
									failed_q <= 1'b0;
								end
								state_q <= ST_IDLE;
							end
						end else begin
							gap_q   <= gap_inc;
							state_q <= ST_IDLE;
						end
					end else begin
						neg_q  <= diff[SAMPLE_WIDTH];
						k_q    <= gap_q;
						copy_q <= !seen_q;
						if (gap_q == '0) begin
							state_q <= ST_FINAL;
						end else if (!seen_q) begin
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (div_st.done) begin
						qs_q    <= div_quo;
						rs_q    <= {div_rem, 1'b0};
						acc_q   <= '0;
						racc_q  <= (GAP_W+1)'(gap_inc);
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (push_ok) begin
						out_valid_q    <= 1'b1;
						out_value_q    <= copy_q ? sample_q : interp_val;
						out_status_q   <= STAT_OK;
						out_run_last_q <= 1'b0;
						out_end_q      <= 1'b0;
						acc_q          <= quo_next;
						racc_q         <= rem_next;
						k_q            <= k_q - GAP_W'(1);
						if (k_q == GAP_W'(1)) begin
							state_q <= ST_FINAL;
						end
					end
				end
				ST_FINAL: begin
					if (push_ok) begin
						out_valid_q    <= 1'b1;
						out_value_q    <= sample_q;
						out_status_q   <= STAT_OK;
						out_run_last_q <= 1'b1;
						out_end_q      <= last_q;
						anchor_q       <= sample_q;
						gap_q          <= '0;
						seen_q         <= 1'b1;
						if (last_q) begin
							anchor_q <= '0;
							seen_q   <= 1'b0;
							failed_q <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`SGLI_ASSERT_IMPL(a_div_in_div_state, clk, arst_n, div_st.busy || div_st.done, state_q == ST_DIV, "divider active outside divide state")
	`SGLI_ASSERT_IMPL(a_emit_count, clk, arst_n, state_q == ST_EMIT, (k_q != '0) && (gap_q != '0), "fill count empty while emitting")
	`SGLI_ASSERT_IMPL(a_rem_bound, clk, arst_n, (state_q == ST_EMIT) && !copy_q, racc_q < two_den, "fill remainder out of range")

endmodule
